// ===== sv/icpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpc_pkg
// Shared types, register map constants and helpers of the interconnect
// performance counter unit.
// ----------------------------------------------------------------------------
package icpc_pkg;

  // Default configuration
  localparam int unsigned NumCountersDef   = 5;
  localparam int unsigned CounterStrideDef = 4096;

  // Field widths
  localparam int unsigned KindW  = 2;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned DataW  = 32;
  localparam int unsigned EvIdW  = 8;
  localparam int unsigned FlagsW = 5;

  // Register map
  localparam logic [AddrW-1:0] CtrlAddr  = 16'h0100;
  localparam int unsigned      CntrBase  = 32'h9000;
  localparam int unsigned      OffEvSel  = 32'h0;
  localparam int unsigned      OffValue  = 32'h4;
  localparam int unsigned      OffCntEn  = 32'h8;
  localparam int unsigned      OffOvf    = 32'hC;
  localparam int unsigned      NcntLsb   = 11;
  localparam int unsigned      NcntW     = 5;
  localparam int unsigned      GlobEnBit = 0;

  // Event code ranges
  localparam logic [4:0] SlaveCodeMax  = 5'h13;
  localparam logic [4:0] MasterCodeMin = 5'h14;
  localparam logic [4:0] MasterCodeMax = 5'h1A;
  localparam logic [2:0] SlaveSrcMax   = 3'd4;

  typedef enum logic [KindW-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2
  } icpc_kind_e;

  // One input transaction as held in the input register
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
    logic             event_valid;
    logic [EvIdW-1:0] event_id;
  } icpc_item_t;

  // Source 0..4 carries slave codes, source 5..7 carries master codes
  function automatic logic id_is_valid(input logic [EvIdW-1:0] id);
    logic [2:0] src;
    logic [4:0] code;
    src  = id[7:5];
    code = id[4:0];
    return ((src <= SlaveSrcMax) && (code <= SlaveCodeMax)) ||
           ((src > SlaveSrcMax) && (code >= MasterCodeMin) && (code <= MasterCodeMax));
  endfunction

endpackage

// ===== sv/icpc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpc_in_if
// Request channel: bus read, bus write or tick transactions.
// ----------------------------------------------------------------------------
interface icpc_in_if;
  import icpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [AddrW-1:0] address;
  logic [DataW-1:0] write_data;
  logic             event_valid;
  logic [EvIdW-1:0] event_id;

  modport source (
    output valid, kind, address, write_data, event_valid, event_id,
    input  ready
  );

  modport sink (
    input  valid, kind, address, write_data, event_valid, event_id,
    output ready
  );
endinterface

// ===== sv/icpc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpc_out_if
// Response channel: read data and overflow status per transaction.
// ----------------------------------------------------------------------------
interface icpc_out_if;
  import icpc_pkg::*;

  logic              valid;
  logic              ready;
  logic [DataW-1:0]  read_data;
  logic [FlagsW-1:0] overflow_flags;
  logic              overflow_irq;

  modport source (
    output valid, read_data, overflow_flags, overflow_irq,
    input  ready
  );

  modport sink (
    input  valid, read_data, overflow_flags, overflow_irq,
    output ready
  );
endinterface

// ===== sv/icpc_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpc_in_stage
// Input register: captures one request transaction per cycle while it is free
// and holds it until the register file consumes it.
// ----------------------------------------------------------------------------
module icpc_in_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  icpc_in_if.sink                item_i,
  input  logic                   take_i,
  output logic                   item_valid_o,
  output icpc_pkg::icpc_item_t   item_o
);
  import icpc_pkg::*;

  logic       valid_q;
  icpc_item_t item_q;

  // Free when empty or when the held transaction leaves this cycle
  assign item_i.ready = !valid_q || take_i;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (item_i.ready) begin
      valid_q <= item_i.valid;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      item_q.kind        <= item_i.kind;
      item_q.address     <= item_i.address;
      item_q.write_data  <= item_i.write_data;
      item_q.event_valid <= item_i.event_valid;
      item_q.event_id    <= item_i.event_id;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== sv/icpc_regfile.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpc_regfile
// Counter state, address decode, tick update and the response register.
// ----------------------------------------------------------------------------
module icpc_regfile #(
  parameter int unsigned NUM_COUNTERS   = icpc_pkg::NumCountersDef,
  parameter int unsigned COUNTER_STRIDE = icpc_pkg::CounterStrideDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  icpc_pkg::icpc_item_t item_i,
  output logic                 take_o,
  icpc_out_if.source           result_o
);
  import icpc_pkg::*;

  logic                    gen_q, gen_d;
  logic [DataW-1:0]        val_q [NUM_COUNTERS];
  logic [DataW-1:0]        val_d [NUM_COUNTERS];
  logic [EvIdW-1:0]        sel_q [NUM_COUNTERS];
  logic [EvIdW-1:0]        sel_d [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0] en_q, en_d;
  logic [NUM_COUNTERS-1:0] ovf_q, ovf_d;
  logic [NUM_COUNTERS+FlagsW-1:0] ovf_pad;

  logic [NUM_COUNTERS-1:0] rd_hit;
  logic [DataW-1:0]        rd_cnt [NUM_COUNTERS];
  logic [DataW-1:0]        rd_data;
  logic                    ctrl_hit;
  logic                    is_rd, is_wr, is_tick;
  logic                    ev_ok;
  logic [DataW-1:0]        addr_ext;

  logic                    out_valid_q;
  logic [DataW-1:0]        rdata_q;
  logic [FlagsW-1:0]       flags_q;
  logic                    irq_q;

  // Handshake: consume when the response register is free
  assign take_o  = item_valid_i && (!out_valid_q || result_o.ready);

  assign is_rd    = take_o && (item_i.kind == KIND_READ);
  assign is_wr    = take_o && (item_i.kind == KIND_WRITE);
  assign is_tick  = take_o && (item_i.kind == KIND_TICK);
  assign ctrl_hit = (item_i.address == CtrlAddr);
  assign ev_ok    = item_i.event_valid && id_is_valid(item_i.event_id);
  assign addr_ext = {{(DataW-AddrW){1'b0}}, item_i.address};

  // Global enable
  assign gen_d = (is_wr && ctrl_hit) ? item_i.write_data[GlobEnBit] : gen_q;

  // Per-counter decode and update
  for (genvar i = 0; i < NUM_COUNTERS; i++) begin : g_cnt
    localparam int unsigned Base    = CntrBase + i * COUNTER_STRIDE;
    localparam bit          IsCycle = (i == 0);

    logic hit_sel, hit_val, hit_en, hit_ovf, inc;

    assign hit_sel = (addr_ext == DataW'(Base + OffEvSel));
    assign hit_val = (addr_ext == DataW'(Base + OffValue));
    assign hit_en  = (addr_ext == DataW'(Base + OffCntEn));
    assign hit_ovf = (addr_ext == DataW'(Base + OffOvf));

    // When enabled, the cycle counter counts every tick, event counters a matching valid id
    assign inc = is_tick && gen_q && en_q[i] &&
                 (IsCycle || (ev_ok && (sel_q[i] == item_i.event_id)));

    always_comb begin
      val_d[i] = val_q[i];
      sel_d[i] = sel_q[i];
      en_d[i]  = en_q[i];
      ovf_d[i] = ovf_q[i];
      if (is_wr) begin
        if (hit_sel) sel_d[i] = item_i.write_data[EvIdW-1:0];
        if (hit_val) val_d[i] = item_i.write_data;
        if (hit_en)  en_d[i]  = item_i.write_data[0];
        if (hit_ovf && item_i.write_data[0]) ovf_d[i] = 1'b0;
      end else if (inc) begin
        val_d[i] = val_q[i] + DataW'(1);
        if (&val_q[i]) ovf_d[i] = 1'b1;
      end
    end

    // Read-back for this counter, zero when not addressed
    always_comb begin
      rd_hit[i] = hit_sel || hit_val || hit_en || hit_ovf;
      rd_cnt[i] = '0;
      if (hit_sel)      rd_cnt[i] = {{(DataW-EvIdW){1'b0}}, sel_q[i]};
      else if (hit_val) rd_cnt[i] = val_q[i];
      else if (hit_en)  rd_cnt[i] = {{(DataW-1){1'b0}}, en_q[i]};
      else if (hit_ovf) rd_cnt[i] = {{(DataW-1){1'b0}}, ovf_q[i]};
    end
  end

  // Read mux: at most one counter register matches
  always_comb begin
    rd_data = '0;
    if (ctrl_hit) begin
      rd_data[NcntLsb +: NcntW] = NcntW'(NUM_COUNTERS - 1);
      rd_data[GlobEnBit]        = gen_q;
    end else begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        if (rd_hit[i]) rd_data = rd_data | rd_cnt[i];
      end
    end
  end

  assign ovf_pad = {{FlagsW{1'b0}}, ovf_d};

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= 1'b0;
      en_q  <= '0;
      ovf_q <= '0;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        val_q[i] <= '0;
        sel_q[i] <= '0;
      end
    end else begin
      gen_q <= gen_d;
      en_q  <= en_d;
      ovf_q <= ovf_d;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        val_q[i] <= val_d[i];
        sel_q[i] <= sel_d[i];
      end
    end
  end

  // Response register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || result_o.ready) begin
      out_valid_q <= item_valid_i;
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      rdata_q <= is_rd ? rd_data : '0;
      flags_q <= ovf_pad[FlagsW-1:0];
      irq_q   <= |ovf_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.read_data      = rdata_q;
  assign result_o.overflow_flags = flags_q;
  assign result_o.overflow_irq   = irq_q;

  // Assertions
  a_no_take_when_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |-> !take_o)
    else $error("transaction consumed while response is stalled");

  a_rdata_zero_non_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && (item_i.kind != KIND_READ)) |=> (result_o.read_data == '0))
    else $error("nonzero read data on a non-read transaction");

  a_ovf_rise_only_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !is_tick |=> ((ovf_q & ~$past(ovf_q)) == '0))
    else $error("overflow flag set outside a tick");

  a_frozen_when_disabled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_tick && !gen_q) |=> (ovf_q == $past(ovf_q)) && (val_q[0] == $past(val_q[0])))
    else $error("counter advanced while globally disabled");

endmodule

// ===== sv/interconnect_perf_counter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interconnect_perf_counter_unit
// Performance monitor with a cycle counter and event counters behind a
// register map, driven by read, write and tick transactions.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake      Payload
//  item_i    in         valid/ready    kind, address, write_data,
//                                      event_valid, event_id
//  result_o  out        valid/ready    read_data, overflow_flags, overflow_irq
//
//  One transaction per cycle sustained while result_o is ready; a transaction
//  passes the input register, then the response register, before its response
//  is valid.
//  Register updates take effect when the transaction leaves the input
//  register, so each transaction sees all earlier ones.
//  A stalled response holds the input register; input is still accepted
//  while the input register is empty.
//  Asynchronous active-low reset clears all counters, selects and flags.
// ----------------------------------------------------------------------------
module interconnect_perf_counter_unit #(
  parameter int unsigned NUM_COUNTERS   = icpc_pkg::NumCountersDef,
  parameter int unsigned COUNTER_STRIDE = icpc_pkg::CounterStrideDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  icpc_in_if.sink    item_i,
  icpc_out_if.source result_o
);
  import icpc_pkg::*;

  logic       take;
  logic       item_valid;
  icpc_item_t item;

  icpc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  icpc_regfile #(
    .NUM_COUNTERS   (NUM_COUNTERS),
    .COUNTER_STRIDE (COUNTER_STRIDE)
  ) u_regfile (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .result_o     (result_o)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the interconnect performance counter unit against a cycle-free
// shadow of its register state. Every accepted transaction updates the shadow
// and queues the expected response; every response is matched field by field
// against the oldest queued one. A short directed run covers the special
// register map and event id cases. A long random run follows, with random
// gaps on both channels, a long response hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module testbench;
  import icpc_pkg::*;

  localparam int unsigned NumCnt      = NumCountersDef;
  localparam int unsigned Stride      = CounterStrideDef;
  localparam logic [KindW-1:0] KindNop = 2'd3;
  localparam int          RandItems   = 1000;
  localparam int          LongHold    = 300;
  localparam int          StallLimit  = 2000;
  localparam int          DrainCycles = 8;
  localparam int          MaxReports  = 10;

  typedef struct packed {
    logic [DataW-1:0]  read_data;
    logic [FlagsW-1:0] flags;
    logic              irq;
  } rsp_t;

  // Shadow of the register state plus the queue of expected responses
  class counter_shadow;
    bit             glob_en;
    bit [DataW-1:0] value  [NumCnt];
    bit             cnt_en [NumCnt];
    bit [EvIdW-1:0] sel    [NumCnt];
    bit             ovf    [NumCnt];
    rsp_t           rsp_q[$];
    int             errors;

    function bit id_counts(bit [EvIdW-1:0] id);
      bit [2:0] src;
      bit [4:0] code;
      src  = id[7:5];
      code = id[4:0];
      if (src <= SlaveSrcMax) return code <= SlaveCodeMax;
      return (code >= MasterCodeMin) && (code <= MasterCodeMax);
    endfunction

    // Counter region decode; unaligned or out-of-range offsets miss
    function bit decode(input bit [AddrW-1:0] addr, output int idx,
                        output int unsigned off);
      int unsigned rel;
      idx = 0;
      off = 0;
      if (addr < CntrBase) return 1'b0;
      rel = addr - CntrBase;
      idx = rel / Stride;
      off = rel % Stride;
      if (idx >= NumCnt) return 1'b0;
      return (off == OffEvSel) || (off == OffValue) || (off == OffCntEn) ||
             (off == OffOvf);
    endfunction

    function bit [DataW-1:0] reg_read(bit [AddrW-1:0] addr);
      int          idx;
      int unsigned off;
      bit [DataW-1:0] word;
      word = '0;
      if (addr == CtrlAddr) begin
        word[NcntLsb +: NcntW] = NcntW'(NumCnt - 1);
        word[GlobEnBit]        = glob_en;
      end else if (decode(addr, idx, off)) begin
        case (off)
          OffEvSel: word = DataW'(sel[idx]);
          OffValue: word = value[idx];
          OffCntEn: word = DataW'(cnt_en[idx]);
          default:  word = DataW'(ovf[idx]);
        endcase
      end
      return word;
    endfunction

    function void reg_write(bit [AddrW-1:0] addr, bit [DataW-1:0] data);
      int          idx;
      int unsigned off;
      if (addr == CtrlAddr) begin
        glob_en = data[GlobEnBit];
      end else if (decode(addr, idx, off)) begin
        case (off)
          OffEvSel: sel[idx]    = data[EvIdW-1:0];
          OffValue: value[idx]  = data;
          OffCntEn: cnt_en[idx] = data[0];
          default: begin
            if (data[0]) ovf[idx] = 1'b0;
          end
        endcase
      end
    endfunction

    // When enabled, the cycle counter counts every tick; event counters need a matching valid id
    function void advance(bit ev_valid, bit [EvIdW-1:0] id);
      bit ev_ok;
      ev_ok = ev_valid && id_counts(id);
      if (!glob_en) return;
      for (int i = 0; i < NumCnt; i++) begin
        if (cnt_en[i] && ((i == 0) || (ev_ok && (sel[i] == id)))) begin
          value[i]++;
          if (value[i] == '0) ovf[i] = 1'b1;
        end
      end
    endfunction

    function void note_request(bit [KindW-1:0] kind, bit [AddrW-1:0] addr,
                               bit [DataW-1:0] data, bit ev_valid,
                               bit [EvIdW-1:0] id);
      rsp_t exp;
      exp = '0;
      case (kind)
        KIND_READ:  exp.read_data = reg_read(addr);
        KIND_WRITE: reg_write(addr, data);
        KIND_TICK:  advance(ev_valid, id);
        default: ;
      endcase
      for (int i = 0; i < NumCnt; i++) begin
        if (ovf[i]) begin
          exp.irq = 1'b1;
          if (i < FlagsW) exp.flags[i] = 1'b1;
        end
      end
      rsp_q.push_back(exp);
    endfunction

    function void mismatch(string what, logic [DataW-1:0] exp,
                           logic [DataW-1:0] got);
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp, got);
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (rsp_q.size() == 0) begin
        mismatch("unrequested response", '0, got.read_data);
        return;
      end
      exp = rsp_q.pop_front();
      if (got.read_data !== exp.read_data) mismatch("read_data", exp.read_data, got.read_data);
      if (got.flags !== exp.flags)         mismatch("overflow_flags", exp.flags, got.flags);
      if (got.irq !== exp.irq)             mismatch("overflow_irq", exp.irq, got.irq);
    endfunction

    function int pending();
      return rsp_q.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic hold_tog = 1'b0;
  int   gap_free = 0;
  int   stall_cycles = 0;
  counter_shadow shadow;

  icpc_in_if  req_if ();
  icpc_out_if rsp_if ();

  interconnect_perf_counter_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (req_if),
    .result_o (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  // Mostly no gap, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [AddrW-1:0] cnt_addr(int idx, int unsigned off);
    return AddrW'(CntrBase + idx * Stride + off);
  endfunction

  function automatic logic [EvIdW-1:0] counted_id();
    if ($urandom_range(0, 1))
      return {3'($urandom_range(0, 4)), 5'($urandom_range(0, SlaveCodeMax))};
    return {3'($urandom_range(5, 7)), 5'($urandom_range(MasterCodeMin, MasterCodeMax))};
  endfunction

  // One request transaction, preceded by a random gap unless gap_free is set
  task automatic send(input logic [KindW-1:0] kind, input logic [AddrW-1:0] addr,
                      input logic [DataW-1:0] data, input logic ev_valid,
                      input logic [EvIdW-1:0] id);
    int gap;
    gap = (gap_free > 0) ? 0 : idle_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.kind        <= kind;
    req_if.address     <= addr;
    req_if.write_data  <= data;
    req_if.event_valid <= ev_valid;
    req_if.event_id    <= id;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    shadow.note_request(kind, addr, data, ev_valid, id);
  endtask

  task automatic directed_items();
    logic [EvIdW-1:0] sels [4];
    sels = '{8'h13, 8'h14, 8'hFA, 8'hB4};
    // control register: reset read, enable with ignored bits all set
    send(KIND_READ,  CtrlAddr, '1, 1'b1, 8'hFF);
    send(KIND_WRITE, CtrlAddr, '1, 1'b1, 8'hFF);
    // cycle counter wraps on ticks without an event
    send(KIND_WRITE, cnt_addr(0, OffCntEn), 32'h1, 1'b0, 8'h00);
    send(KIND_WRITE, cnt_addr(0, OffValue), 32'hFFFF_FFFE, 1'b0, 8'h00);
    send(KIND_TICK,  16'h0000, '0, 1'b0, 8'hFF);
    send(KIND_TICK,  16'hFFFF, '1, 1'b0, 8'hFF);
    send(KIND_WRITE, cnt_addr(0, OffOvf), 32'h1, 1'b0, 8'h00);
    // cycle counter select is kept but unused
    send(KIND_WRITE, cnt_addr(0, OffEvSel), 32'hFFFF_FF13, 1'b0, 8'h00);
    // event counters: valid slave id, invalid id, two master ids
    for (int i = 0; i < 4; i++) begin
      send(KIND_WRITE, cnt_addr(i + 1, OffEvSel), {24'hABCDEF, sels[i]}, 1'b0, 8'h00);
      send(KIND_WRITE, cnt_addr(i + 1, OffCntEn), 32'hFFFF_FFFF, 1'b0, 8'h00);
    end
    send(KIND_WRITE, cnt_addr(1, OffValue), 32'hFFFF_FFFF, 1'b0, 8'h00);
    for (int i = 0; i < 4; i++) send(KIND_TICK, '0, '0, 1'b1, sels[i]);
    send(KIND_TICK, '0, '0, 1'b0, 8'h13);
    // unused kind, an unaligned offset and an out-of-range counter
    send(KindNop,    cnt_addr(1, OffOvf), 32'h1, 1'b1, 8'h13);
    send(KIND_READ,  16'h9001, '0, 1'b0, 8'h00);
    send(KIND_READ,  cnt_addr(NumCnt, OffValue), '0, 1'b0, 8'h00);
    // global disable freezes every counter
    send(KIND_WRITE, CtrlAddr, 32'hFFFF_FFFE, 1'b0, 8'h00);
    send(KIND_TICK,  '0, '0, 1'b1, 8'hFA);
    send(KIND_READ,  cnt_addr(3, OffValue), '0, 1'b0, 8'h00);
  endtask

  // Mostly legal register traffic and ticks on selected ids, some noise
  task automatic random_item();
    int               r;
    int               idx;
    int unsigned      off;
    logic [DataW-1:0] data;
    logic [EvIdW-1:0] id;
    logic             ev;
    r    = $urandom_range(0, 99);
    idx  = $urandom_range(0, NumCnt - 1);
    off  = 4 * $urandom_range(0, 3);
    data = $urandom();
    id   = EvIdW'($urandom_range(0, 255));
    ev   = 1'($urandom_range(0, 1));
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          ev = 1'b1;
          id = shadow.sel[$urandom_range(1, NumCnt - 1)];
        end
        2: ev = 1'b1;
        default: ev = 1'b0;
      endcase
      send(KIND_TICK, AddrW'($urandom()), data, ev, id);
    end else if (r < 62) begin
      if ($urandom_range(0, 5) == 0) send(KIND_READ, CtrlAddr, data, ev, id);
      else send(KIND_READ, cnt_addr(idx, off), data, ev, id);
    end else if (r < 80) begin
      if ($urandom_range(0, 7) == 0) begin
        data[GlobEnBit] = ($urandom_range(0, 99) < 85);
        send(KIND_WRITE, CtrlAddr, data, ev, id);
      end else begin
        case (off)
          OffValue: if ($urandom_range(0, 1)) data = 32'hFFFF_FFFF - $urandom_range(0, 6);
          OffEvSel: if ($urandom_range(0, 3) != 0) data[EvIdW-1:0] = counted_id();
          OffCntEn: data[0] = ($urandom_range(0, 99) < 80);
          default: ;
        endcase
        send(KIND_WRITE, cnt_addr(idx, off), data, ev, id);
      end
    end else if (r < 92) begin
      // unmapped or nearly mapped addresses
      if ($urandom_range(0, 1))
        send(KIND_READ, AddrW'($urandom()), data, ev, id);
      else if ($urandom_range(0, 1))
        send(KIND_WRITE, cnt_addr(idx, $urandom_range(0, 15)), data, ev, id);
      else
        send(KIND_WRITE, cnt_addr($urandom_range(NumCnt, 6), off), data, ev, id);
    end else if (r < 97) begin
      send(KindNop, AddrW'($urandom()), data, ev, id);
    end else begin
      send(KIND_WRITE, cnt_addr(idx, OffOvf), data, ev, id);
    end
  endtask

  // Response side: random ready runs and stalls, plus one requested long hold
  initial begin : rsp_driver
    int run;
    int hold;
    bit rdy;
    bit seen;
    run  = 0;
    hold = 0;
    rdy  = 1'b0;
    seen = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_tog != seen) begin
        seen = hold_tog;
        hold = LongHold;
      end
      if (hold > 0) begin
        hold--;
        rdy = 1'b0;
      end else begin
        if (run == 0) begin
          rdy = ($urandom_range(0, 99) < 70);
          run = rdy ? $urandom_range(1, 60) : idle_len() + 1;
        end
        run--;
      end
      rsp_if.ready <= rdy;
    end
  end

  // Response check and stall watchdog
  always @(posedge clk_i) begin : rsp_monitor
    rsp_t got;
    if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got.read_data = rsp_if.read_data;
      got.flags     = rsp_if.overflow_flags;
      got.irq       = rsp_if.overflow_irq;
      shadow.check_response(got);
    end
    if (!rst_ni || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    shadow = new();
    req_if.valid       = 1'b0;
    req_if.kind        = '0;
    req_if.address     = '0;
    req_if.write_data  = '0;
    req_if.event_valid = 1'b0;
    req_if.event_id    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_items();
    for (int n = 0; n < RandItems; n++) begin
      // long response hold while requests keep coming back to back
      if (n == 300) begin
        hold_tog <= ~hold_tog;
        gap_free = 60;
      end
      // drain pause: wait for every outstanding response
      if (n == 650) begin
        req_if.valid <= 1'b0;
        do @(posedge clk_i); while (shadow.pending() != 0);
      end
      if (gap_free == 0 && $urandom_range(0, 99) < 3) gap_free = $urandom_range(20, 60);
      random_item();
      if (gap_free > 0) gap_free--;
    end
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (shadow.pending() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
